// ----- sv/mhfd_pkg.sv -----
// shared types and constants for the magic header frame deframer
// no dependencies; imported by mhfd_parser, the top level and the testbench
package mhfd_pkg;

  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned HDR_BITS     = 8 * HEADER_BYTES;
  localparam int unsigned CNT_W        = $clog2(HEADER_BYTES);

  localparam logic [31:0]      MAGIC_RESET = 32'h5450_3033;
  localparam logic [CNT_W-1:0] CNT_LAST    = CNT_W'(HEADER_BYTES - 1);

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_DEAD    = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seq_number;
    logic [31:0] msg_type;
    logic [31:0] payload_len;
    logic [7:0]  payload_byte;
    logic        last;
  } res_t;

endpackage

// ----- sv/mhfd_parser.sv -----
// frame state: header collection, payload countdown, dead after bad magic
// depends on mhfd_pkg; state advances only when the top level steps a word
module mhfd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic [31:0]         magic_word,
  output logic                produce,
  output mhfd_pkg::res_t      res
);
  import mhfd_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [31:0]            left_r, left_nxt;
  logic [HDR_BITS-9:0]    hdr_r, hdr_nxt;
  logic [HDR_BITS-1:0]    full_hdr;
  logic                   is_last;

  assign full_hdr = {hdr_r, rx_byte};
  assign is_last  = (left_r <= 32'd1);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    left_nxt  = left_r;
    hdr_nxt   = hdr_r;
    produce   = 1'b0;
    res       = '0;
    unique case (phase_r)
      PH_PAYLOAD: begin
        produce          = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = rx_byte;
        res.last         = is_last;
        if (is_last) begin
          left_nxt  = '0;
          phase_nxt = PH_HEADER;
          cnt_nxt   = '0;
        end else begin
          left_nxt = left_r - 32'd1;
        end
      end
      PH_HEADER: begin
        hdr_nxt = full_hdr[HDR_BITS-9:0];
        if (cnt_r != CNT_LAST) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          cnt_nxt = '0;
          produce = 1'b1;
          if (full_hdr[127:96] != magic_word) begin
            phase_nxt = PH_DEAD;
            res.kind  = KIND_ERROR;
          end else begin
            res.kind        = KIND_HEADER;
            res.seq_number  = full_hdr[95:64];
            res.msg_type    = full_hdr[63:32];
            res.payload_len = full_hdr[31:0];
            // empty payload closes the frame on the header itself
            if (full_hdr[31:0] == 32'd0) begin
              res.last  = 1'b1;
              phase_nxt = PH_HEADER;
            end else begin
              left_nxt  = full_hdr[31:0];
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
      end
      default: begin
        // dead: swallow everything until reset
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      cnt_r   <= '0;
      left_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      left_r  <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      hdr_r <= hdr_nxt;
    end
  end

endmodule

// ----- sv/magic_header_frame_deframer_top.sv -----
// magic header frame deframer: input word register, parser, result register
// a result is registered on out_ when the parser steps the byte held in the input word register
// throughput: one byte per cycle; a byte that gives no result never waits
// on the result register, one that does waits only while a result is stalled
// reset (rst_n low, synchronous) empties both registers, returns the parser
// to header collection and reloads magic_word with "TP03"
module magic_header_frame_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [31:0] out_seq_number,
  output logic [31:0] out_msg_type,
  output logic [31:0] out_payload_len,
  output logic [7:0]  out_payload_byte,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_magic_word
);
  import mhfd_pkg::*;

  logic        stg_v_r;
  logic [7:0]  stg_byte_r;
  logic [31:0] magic_r;
  logic        out_v_r;
  res_t        out_r;
  logic        produce;
  res_t        res;
  logic        step;
  logic        out_free;

  mhfd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .rx_byte    (stg_byte_r),
    .magic_word (magic_r),
    .produce    (produce),
    .res        (res)
  );

  assign out_free = !out_v_r || !out_stall;
  assign step     = stg_v_r && (out_free || !produce);
  assign in_stall = stg_v_r && !step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      out_v_r <= 1'b0;
      magic_r <= MAGIC_RESET;
    end else begin
      if (!in_stall) begin
        stg_v_r <= in_valid;
      end
      if (step && produce) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        magic_r <= cfg_magic_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stg_byte_r <= in_rx_byte;
    end
    if (step && produce) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_v_r;
  assign out_kind         = out_r.kind;
  assign out_seq_number   = out_r.seq_number;
  assign out_msg_type     = out_r.msg_type;
  assign out_payload_len  = out_r.payload_len;
  assign out_payload_byte = out_r.payload_byte;
  assign out_last         = out_r.last;

  // a held result must never be overwritten by a new one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_stall |-> !(step && produce))
    else $error("result register overwritten while stalled");

  // the input side only stalls when the word register is occupied
  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stg_v_r && produce && out_v_r)
    else $error("input stalled without a pending result");

  // an error result never closes a frame
  a_error_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_r.kind == KIND_ERROR) |-> !out_r.last)
    else $error("error result marked last");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_v_r && !stg_v_r)
    else $error("registers not emptied by reset");

endmodule

// ----- tb/sv/tb_magic_header_frame_deframer_top.sv -----
// self-checking testbench for magic_header_frame_deframer_top: random frames, stalls, magic changes
// depends on mhfd_pkg and the deframer rtl; the scoreboard predicts each result word itself
module tb_magic_header_frame_deframer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mhfd_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned WORDS_PER_SETTING = 230;

  // predicts deframer output words and checks the ones the block delivers
  class frame_scoreboard;
    logic [31:0]      magic;
    phase_t           phase;
    logic [CNT_W-1:0] hdr_count;
    logic [63:0]      hdr_shift [2];
    logic [31:0]      bytes_left;
    res_t             expected_q [$];
    int unsigned      errors;
    int unsigned      n_header;
    int unsigned      n_payload;
    int unsigned      n_error;

    function new();
      magic      = MAGIC_RESET;
      phase      = PH_HEADER;
      hdr_count  = '0;
      hdr_shift[0] = '0;
      hdr_shift[1] = '0;
      bytes_left = '0;
      errors     = 0;
      n_header   = 0;
      n_payload  = 0;
      n_error    = 0;
    endfunction

    function void set_magic(logic [31:0] m);
      magic = m;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_byte(logic [7:0] b);
      res_t        r;
      logic [31:0] mg;
      logic [31:0] ln;
      r = '0;
      case (phase)
        PH_PAYLOAD: begin
          r.kind         = KIND_PAYLOAD;
          r.payload_byte = b;
          r.last         = (bytes_left <= 32'd1);
          if (r.last) begin
            bytes_left = '0;
            phase      = PH_HEADER;
            hdr_count  = '0;
          end else begin
            bytes_left = bytes_left - 32'd1;
          end
          expected_q.push_back(r);
        end
        PH_HEADER: begin
          if (hdr_count < HEADER_BYTES / 2) hdr_shift[0] = {hdr_shift[0][55:0], b};
          else hdr_shift[1] = {hdr_shift[1][55:0], b};
          if (hdr_count != CNT_LAST) begin
            hdr_count = hdr_count + 1'b1;
          end else begin
            hdr_count = '0;
            mg = hdr_shift[0][63:32];
            ln = hdr_shift[1][31:0];
            if (mg != magic) begin
              phase  = PH_DEAD;
              r.kind = KIND_ERROR;
            end else begin
              r.kind        = KIND_HEADER;
              r.seq_number  = hdr_shift[0][31:0];
              r.msg_type    = hdr_shift[1][63:32];
              r.payload_len = ln;
              r.last        = (ln == 32'd0);
              if (ln != 32'd0) begin
                bytes_left = ln;
                phase      = PH_PAYLOAD;
              end
            end
            expected_q.push_back(r);
          end
        end
        default: ;  // dead: every byte is dropped
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d", got.kind));
      end else begin
        want = expected_q.pop_front();
        check_field("kind", 32'(got.kind), 32'(want.kind));
        check_field("seq_number", got.seq_number, want.seq_number);
        check_field("msg_type", got.msg_type, want.msg_type);
        check_field("payload_len", got.payload_len, want.payload_len);
        check_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
        check_field("last", 32'(got.last), 32'(want.last));
        case (want.kind)
          KIND_HEADER:  n_header++;
          KIND_PAYLOAD: n_payload++;
          default:      n_error++;
        endcase
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [31:0] out_seq_number;
  logic [31:0] out_msg_type;
  logic [31:0] out_payload_len;
  logic [7:0]  out_payload_byte;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_magic_word = '0;

  frame_scoreboard sb = new();

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned bytes_sent = 0;
  int unsigned settings_used = 1;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  magic_header_frame_deframer_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_seq_number   (out_seq_number),
    .out_msg_type     (out_msg_type),
    .out_payload_len  (out_payload_len),
    .out_payload_byte (out_payload_byte),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_magic_word   (cfg_magic_word)
  );

  always #2 clk = ~clk;

  // receiver: checks each accepted word, stalls at random or for a long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_result({out_kind, out_seq_number, out_msg_type, out_payload_len,
                         out_payload_byte, out_last});
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle);
    end
  end

  // valid is never dropped and raised in one step
  task send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task send_word32(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
  endtask

  task send_frame(input logic [31:0] mg, input logic [31:0] seq, input logic [31:0] typ,
                  input logic [31:0] len);
    send_word32(mg);
    send_word32(seq);
    send_word32(typ);
    send_word32(len);
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(255)));
  endtask

  task send_random_frame();
    int unsigned r;
    logic [31:0] len;
    r = $urandom_range(99);
    if (r < 25) len = 0;
    else if (r < 90) len = $urandom_range(8, 1);
    else len = $urandom_range(40, 9);
    send_frame(sb.magic, $urandom, $urandom, len);
  endtask

  // lets the block go quiet: all words back plus its latency and some margin
  task drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_magic(input logic [31:0] m);
    drain();
    cfg_valid      <= 1'b1;
    cfg_magic_word <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_magic(m);
    settings_used++;
  endtask

  initial begin
    logic [31:0] magics [6];
    int unsigned target;
    magics = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, MAGIC_RESET, $urandom, 32'h4100_0042};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset magic, extreme header fields, empty and one-byte payloads
    send_frame(MAGIC_RESET, 32'hFFFF_FFFF, 32'h0000_0000, 32'd0);
    send_frame(MAGIC_RESET, 32'h0000_0000, 32'hFFFF_FFFF, 32'd1);

    for (int p = 0; p < 6; p++) begin
      write_magic(magics[p]);
      case (p / 2)
        0:       begin send_idle = 37; recv_idle = 77; end
        1:       begin send_idle = 77; recv_idle = 37; end
        default: begin send_idle = 0;  recv_idle = 0;  end
      endcase
      if (p == 1 || p == 4) hold_requests <= hold_requests + 1;
      target = bytes_sent + WORDS_PER_SETTING;
      while (bytes_sent < target) send_random_frame();
    end

    // magic with zero bytes: a good frame, then one differing only in its last byte
    send_frame(32'h4100_0042, $urandom, $urandom, 32'd3);
    send_frame(32'h4100_0043, $urandom, $urandom, 32'd2);
    // dead from here on: nothing more may come out
    for (int i = 0; i < 12; i++) send_byte(8'($urandom_range(255)));
    send_frame(32'h4100_0042, $urandom, $urandom, 32'd0);

    drain();
    repeat (20) @(posedge clk);
    $display("%0d bytes sent under %0d magic settings, three idling mixes and two long holds",
             bytes_sent, settings_used);
    $display("checked %0d headers, %0d payload bytes, %0d bad magic words",
             sb.n_header, sb.n_payload, sb.n_error);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d words outstanding", sb.pending());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/mhfd_pkg.sv
sv/mhfd_parser.sv
sv/magic_header_frame_deframer_top.sv
tb/sv/tb_magic_header_frame_deframer_top.sv
